### sv/ppu_pkg.sv
// Package for the packed probability unpacker: widths, codes, the command
// passed from the front end to the back end, and the configuration bundle.
// No dependencies.
package ppu_pkg;

    localparam int ROW_MAX_DEF        = 32;
    localparam int VALUE_BITS_MAX_DEF = 32;

    localparam int BYTE_W    = 8;
    localparam int PLOIDY_W  = 7;
    localparam int MISSING_BIT = 7;
    localparam int BUF_W     = 40;
    localparam int HELD_W    = 6;
    localparam int HELD_LIMIT = 31;
    localparam int CFG_W     = 6;
    localparam int CNT_W     = 6;
    localparam int SKIP_W    = 12;
    localparam int CHN_W     = 8;
    localparam int NUM_W     = 32;
    localparam int SUM_W     = 38;
    localparam int QDEPTH    = 4;

    localparam logic [1:0] KIND_READ = 2'd0;
    localparam logic [1:0] KIND_COMP = 2'd1;
    localparam logic [1:0] KIND_NAN  = 2'd2;

    localparam logic CMD_HEADER = 1'b0;
    localparam logic CMD_DATA   = 1'b1;

    localparam logic [1:0] REG_PHASED  = 2'd0;
    localparam logic [1:0] REG_VBITS   = 2'd1;
    localparam logic [1:0] REG_ALLELES = 2'd2;
    localparam logic [1:0] REG_PLOIDY  = 2'd3;

    typedef struct packed {
        logic             phased;
        logic [CFG_W-1:0] value_bits;
        logic [CFG_W-1:0] alleles;
        logic [CFG_W-1:0] ploidy_limit;
    } ppu_cfg_t;

    typedef struct packed {
        logic              is_hdr;
        logic [BYTE_W-1:0] data;
        logic              pad_now;
        logic [SKIP_W-1:0] skip;
        logic [CNT_W-1:0]  groups;
        logic [CNT_W-1:0]  group_vals;
        logic [CNT_W-1:0]  row_len;
    } ppu_cmd_t;

endpackage

### sv/ppu_choose.sv
// Iterative saturating binomial coefficient unit for the unpacker front end.
// Uses ppu_pkg. One multiply, then a bit-serial restoring divide, per factor.
module ppu_choose
    import ppu_pkg::*;
#(
    parameter int CAP = ROW_MAX_DEF + 1
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [CHN_W-1:0] n,
    input  logic [CNT_W-1:0] k,
    output logic             done,
    output logic [CNT_W-1:0] result
);
    localparam int DIV_W = 14;
    localparam int STEP_W = $clog2(DIV_W);

    typedef enum logic [1:0] {C_IDLE, C_MUL, C_DIV, C_NEXT} cstate_t;

    cstate_t            state_reg, state_next;
    logic [CNT_W-1:0]   kk_reg, kk_next, r_reg, r_next, i_reg, i_next;
    logic [CNT_W-1:0]   rem_reg, rem_next, res_reg, res_next;
    logic [CHN_W-1:0]   mb_reg, mb_next;
    logic [DIV_W-1:0]   div_reg, div_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic               done_reg, done_next;

    logic [CHN_W-1:0]   n_minus_k, kk_start;
    logic [CNT_W:0]     trial;

    assign n_minus_k = n - CHN_W'(k);
    assign kk_start  = (CHN_W'(k) > n_minus_k) ? n_minus_k : CHN_W'(k);
    assign trial     = {rem_reg, div_reg[DIV_W-1]};

    always_comb begin
        state_next = state_reg;
        kk_next = kk_reg; r_next = r_reg; i_next = i_reg; mb_next = mb_reg;
        rem_next = rem_reg; div_next = div_reg; step_next = step_reg;
        res_next = res_reg;
        done_next = 1'b0;
        unique case (state_reg)
            C_IDLE: begin
                if (start) begin
                    kk_next = kk_start[CNT_W-1:0];
                    mb_next = n - kk_start;
                    r_next  = CNT_W'(1);
                    i_next  = CNT_W'(1);
                    if (kk_start == '0) begin
                        res_next  = CNT_W'(1);
                        done_next = 1'b1;
                    end else begin
                        state_next = C_MUL;
                    end
                end
            end
            C_MUL: begin
                div_next   = DIV_W'(r_reg) * (DIV_W'(mb_reg) + DIV_W'(i_reg));
                rem_next   = '0;
                step_next  = STEP_W'(DIV_W - 1);
                state_next = C_DIV;
            end
            C_DIV: begin
                if (trial >= {1'b0, i_reg}) begin
                    rem_next = CNT_W'(trial - {1'b0, i_reg});
                    div_next = {div_reg[DIV_W-2:0], 1'b1};
                end else begin
                    rem_next = trial[CNT_W-1:0];
                    div_next = {div_reg[DIV_W-2:0], 1'b0};
                end
                step_next = step_reg - 1'b1;
                if (step_reg == '0) state_next = C_NEXT;
            end
            C_NEXT: begin
                // The partial products only grow, so an early cap is final.
                if (div_reg > DIV_W'(CAP)) begin
                    res_next   = CNT_W'(CAP);
                    done_next  = 1'b1;
                    state_next = C_IDLE;
                end else if (i_reg == kk_reg) begin
                    res_next   = div_reg[CNT_W-1:0];
                    done_next  = 1'b1;
                    state_next = C_IDLE;
                end else begin
                    r_next     = div_reg[CNT_W-1:0];
                    i_next     = i_reg + 1'b1;
                    state_next = C_MUL;
                end
            end
            default: state_next = C_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= C_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        kk_reg <= kk_next; r_reg <= r_next; i_reg <= i_next; mb_reg <= mb_next;
        rem_reg <= rem_next; div_reg <= div_next; step_reg <= step_next;
        res_reg <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;
endmodule

### sv/ppu_front.sv
// Front end of the unpacker: accepts input transactions, sizes each sample
// row and turns headers into commands. Uses ppu_pkg and ppu_choose.
module ppu_front
    import ppu_pkg::*;
#(
    parameter int ROW_MAX = ROW_MAX_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  ppu_cfg_t          cfg,
    input  logic [CFG_W-1:0]  eff_bits,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_cmd,
    input  logic [BYTE_W-1:0] s_payload,
    input  logic              q_full,
    output logic              q_push,
    output ppu_cmd_t          q_wdata,
    output logic              idle
);
    localparam int CAP = ROW_MAX + 1;

    typedef enum logic [2:0] {F_IDLE, F_ROW, F_ROW_WAIT, F_CNT, F_CNT_WAIT, F_PUSH}
        fstate_t;

    fstate_t             state_reg, state_next;
    logic [PLOIDY_W-1:0] p_reg, p_next;
    logic                miss_reg, miss_next;
    logic [CNT_W-1:0]    row_reg, row_next, cnt_reg, cnt_next;

    logic [CNT_W-1:0]    alleles, am1;
    logic                ch_start, ch_done;
    logic [CHN_W-1:0]    ch_n;
    logic [CNT_W-1:0]    ch_res;
    logic [2*CFG_W-1:0]  row_prod;
    logic [PLOIDY_W+CFG_W-1:0] cnt_prod, nums_prod;
    logic [CNT_W-1:0]    nums, row_clamped_ph, row_clamped_ch, cnt_sat_ph;
    logic                accept, over;

    assign alleles = (cfg.alleles == '0) ? CNT_W'(1) : cfg.alleles;
    assign am1     = alleles - 1'b1;
    assign accept  = s_valid && s_ready;

    assign row_prod  = cfg.ploidy_limit * alleles;
    assign cnt_prod  = p_reg * alleles;
    assign nums_prod = p_reg * am1;

    assign row_clamped_ph = (row_prod > (2*CFG_W)'(ROW_MAX)) ? CNT_W'(ROW_MAX) :
                            (row_prod == '0) ? CNT_W'(1) : row_prod[CNT_W-1:0];
    assign row_clamped_ch = (ch_res > CNT_W'(ROW_MAX)) ? CNT_W'(ROW_MAX) :
                            (ch_res == '0) ? CNT_W'(1) : ch_res;
    assign cnt_sat_ph = (cnt_prod > (PLOIDY_W+CFG_W)'(CAP)) ? CNT_W'(CAP) :
                        cnt_prod[CNT_W-1:0];

    ppu_choose #(.CAP(CAP)) u_choose (
        .aclk(aclk), .aresetn(aresetn), .start(ch_start), .n(ch_n), .k(am1),
        .done(ch_done), .result(ch_res)
    );

    always_comb begin
        ch_n = (state_reg == F_ROW) ? CHN_W'(alleles) + CHN_W'(cfg.ploidy_limit) - 1'b1
                                    : CHN_W'(alleles) + CHN_W'(p_reg) - 1'b1;
    end

    // Command built from the sized row; item counts are exact up to the cap.
    always_comb begin
        over  = cnt_reg > row_reg;
        nums  = cfg.phased ? nums_prod[CNT_W-1:0] : cnt_reg - 1'b1;
        q_wdata = '0;
        q_wdata.is_hdr = (state_reg == F_PUSH);
        q_wdata.data   = s_payload;
        q_wdata.row_len = row_reg;
        if (state_reg == F_PUSH) begin
            if (over) begin
                q_wdata.pad_now = 1'b1;
            end else if (miss_reg) begin
                q_wdata.pad_now = 1'b1;
                q_wdata.skip    = SKIP_W'(eff_bits) * SKIP_W'(nums);
            end else begin
                q_wdata.groups     = cfg.phased ? p_reg[CNT_W-1:0] : CNT_W'(1);
                q_wdata.group_vals = cfg.phased ? am1 : cnt_reg - 1'b1;
                q_wdata.pad_now    = cfg.phased && (p_reg == '0);
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        p_next = p_reg; miss_next = miss_reg; row_next = row_reg; cnt_next = cnt_reg;
        ch_start = 1'b0;
        q_push   = 1'b0;
        s_ready  = (state_reg == F_IDLE) && !q_full;
        unique case (state_reg)
            F_IDLE: begin
                if (accept) begin
                    if (s_cmd == CMD_DATA) begin
                        q_push = 1'b1;
                    end else begin
                        p_next     = s_payload[PLOIDY_W-1:0];
                        miss_next  = s_payload[MISSING_BIT];
                        state_next = F_ROW;
                    end
                end
            end
            F_ROW: begin
                if (cfg.phased) begin
                    row_next   = row_clamped_ph;
                    state_next = F_CNT;
                end else begin
                    ch_start   = 1'b1;
                    state_next = F_ROW_WAIT;
                end
            end
            F_ROW_WAIT: begin
                if (ch_done) begin
                    row_next   = row_clamped_ch;
                    state_next = F_CNT;
                end
            end
            F_CNT: begin
                if (cfg.phased) begin
                    cnt_next   = cnt_sat_ph;
                    state_next = F_PUSH;
                end else begin
                    ch_start   = 1'b1;
                    state_next = F_CNT_WAIT;
                end
            end
            F_CNT_WAIT: begin
                if (ch_done) begin
                    cnt_next   = ch_res;
                    state_next = F_PUSH;
                end
            end
            F_PUSH: begin
                if (!q_full) begin
                    q_push     = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
        p_reg <= p_next; miss_reg <= miss_next; row_reg <= row_next; cnt_reg <= cnt_next;
    end

    assign idle = (state_reg == F_IDLE);
endmodule

### sv/ppu_queue.sv
// Short command queue between the unpacker's front and back ends.
// Uses ppu_pkg for the command type and depth.
module ppu_queue
    import ppu_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  ppu_cmd_t wdata,
    input  logic     pop,
    output ppu_cmd_t rdata,
    output logic     full,
    output logic     empty
);
    localparam int PTR_W = $clog2(QDEPTH);

    ppu_cmd_t           mem [QDEPTH];
    logic [PTR_W-1:0]   wr_reg, rd_reg;
    logic [PTR_W:0]     count_reg;

    always_ff @(posedge aclk) begin
        if (push) mem[wr_reg] <= wdata;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg <= '0;
            rd_reg <= '0;
            count_reg <= '0;
        end else begin
            if (push) wr_reg <= wr_reg + 1'b1;
            if (pop) rd_reg <= rd_reg + 1'b1;
            count_reg <= count_reg + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
        end
    end

    assign rdata = mem[rd_reg];
    assign full  = (count_reg == (PTR_W+1)'(QDEPTH));
    assign empty = (count_reg == '0);
endmodule

### sv/ppu_back.sv
// Back end of the unpacker: holds the bit buffer, runs the per-sample
// groups and drives the result register. Uses ppu_pkg.
module ppu_back
    import ppu_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [CFG_W-1:0] eff_bits,
    input  logic             cfg_clear,
    input  logic             q_empty,
    input  ppu_cmd_t         q_rdata,
    output logic             q_pop,
    output logic             idle,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [NUM_W-1:0] m_numerator,
    output logic [1:0]       m_kind,
    output logic             m_last,
    output logic             m_sum_exceeded
);
    typedef enum logic [1:0] {B_IDLE, B_RUN, B_PAD} bstate_t;

    bstate_t           state_reg, state_next;
    logic [BUF_W-1:0]  buf_reg, buf_next;
    logic [HELD_W-1:0] held_reg, held_next;
    logic [SKIP_W-1:0] skip_reg, skip_next;
    logic [CNT_W-1:0]  groups_reg, groups_next, vleft_reg, vleft_next;
    logic [CNT_W-1:0]  gv_reg, gv_next, rowlen_reg, rowlen_next, emitted_reg, emitted_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic              mv_reg, mv_next, last_reg, last_next, flag_reg, flag_next;
    logic [NUM_W-1:0]  num_reg, num_next;
    logic [1:0]        kind_reg, kind_next;

    logic [NUM_W:0]    denom;
    logic [NUM_W-1:0]  value;
    logic [SKIP_W-1:0] take;
    logic              can_emit;

    assign denom    = ((NUM_W+1)'(1) << eff_bits) - 1'b1;
    assign value    = buf_reg[NUM_W-1:0] & denom[NUM_W-1:0];
    assign take     = (skip_reg < SKIP_W'(held_reg)) ? skip_reg : SKIP_W'(held_reg);
    assign can_emit = !mv_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        buf_next = buf_reg; held_next = held_reg; skip_next = skip_reg;
        groups_next = groups_reg; vleft_next = vleft_reg; gv_next = gv_reg;
        rowlen_next = rowlen_reg; emitted_next = emitted_reg; sum_next = sum_reg;
        mv_next = mv_reg && !m_ready;
        num_next = num_reg; kind_next = kind_reg; last_next = last_reg; flag_next = flag_reg;
        q_pop = 1'b0;
        unique case (state_reg)
            B_IDLE: begin
                if (!q_empty) begin
                    q_pop = 1'b1;
                    if (q_rdata.is_hdr) begin
                        groups_next  = q_rdata.groups;
                        vleft_next   = q_rdata.group_vals;
                        gv_next      = q_rdata.group_vals;
                        rowlen_next  = q_rdata.row_len;
                        skip_next    = q_rdata.skip;
                        sum_next     = '0;
                        emitted_next = '0;
                        state_next   = q_rdata.pad_now ? B_PAD : B_RUN;
                    end else begin
                        // A byte that finds the buffer too full is dropped.
                        if (held_reg <= HELD_W'(HELD_LIMIT)) begin
                            buf_next  = buf_reg | (BUF_W'(q_rdata.data) << held_reg);
                            held_next = held_reg + HELD_W'(BYTE_W);
                        end
                        state_next = B_RUN;
                    end
                end
            end
            B_PAD: begin
                if (emitted_reg >= rowlen_reg) begin
                    state_next = B_RUN;
                end else if (can_emit) begin
                    mv_next = 1'b1; num_next = '0; kind_next = KIND_NAN; flag_next = 1'b0;
                    last_next = (emitted_reg + 1'b1) == rowlen_reg;
                    emitted_next = emitted_reg + 1'b1;
                end
            end
            B_RUN: begin
                if (skip_reg != '0) begin
                    if (take == '0) begin
                        state_next = B_IDLE;
                    end else begin
                        buf_next  = buf_reg >> take;
                        held_next = held_reg - HELD_W'(take);
                        skip_next = skip_reg - take;
                    end
                end else if (groups_reg == '0) begin
                    state_next = B_IDLE;
                end else if (vleft_reg == '0) begin
                    if (can_emit) begin
                        mv_next = 1'b1; kind_next = KIND_COMP;
                        if (sum_reg > SUM_W'(denom)) begin
                            num_next = '0; flag_next = 1'b1;
                        end else begin
                            num_next = NUM_W'(SUM_W'(denom) - sum_reg); flag_next = 1'b0;
                        end
                        last_next = (emitted_reg + 1'b1) == rowlen_reg;
                        emitted_next = emitted_reg + 1'b1;
                        sum_next = '0;
                        groups_next = groups_reg - 1'b1;
                        if (groups_reg == CNT_W'(1)) state_next = B_PAD;
                        else vleft_next = gv_reg;
                    end
                end else if (held_reg >= eff_bits) begin
                    if (can_emit) begin
                        mv_next = 1'b1; num_next = value; kind_next = KIND_READ;
                        flag_next = 1'b0;
                        last_next = (emitted_reg + 1'b1) == rowlen_reg;
                        emitted_next = emitted_reg + 1'b1;
                        buf_next  = buf_reg >> eff_bits;
                        held_next = held_reg - eff_bits;
                        sum_next  = sum_reg + SUM_W'(value);
                        vleft_next = vleft_reg - 1'b1;
                    end
                end else begin
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
        if (cfg_clear) begin
            groups_next = '0; vleft_next = '0; sum_next = '0; skip_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
            buf_reg <= '0; held_reg <= '0; skip_reg <= '0;
            groups_reg <= '0; vleft_reg <= '0; sum_reg <= '0; emitted_reg <= '0;
            mv_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            buf_reg <= buf_next; held_reg <= held_next; skip_reg <= skip_next;
            groups_reg <= groups_next; vleft_reg <= vleft_next; sum_reg <= sum_next;
            emitted_reg <= emitted_next;
            mv_reg <= mv_next;
        end
        gv_reg <= gv_next; rowlen_reg <= rowlen_next;
        num_reg <= num_next; kind_reg <= kind_next; last_reg <= last_next;
        flag_reg <= flag_next;
    end

    assign idle           = (state_reg == B_IDLE);
    assign m_valid        = mv_reg;
    assign m_numerator    = num_reg;
    assign m_kind         = kind_reg;
    assign m_last         = last_reg;
    assign m_sum_exceeded = flag_reg;
endmodule

### sv/packed_probability_unpacker_unit.sv
// Packed probability unpacker: turns a byte stream of per-sample headers and
// LSB-first packed numerators into one padded row of result items per sample.
// Input channel (s_*): s_cmd selects a header byte or a data byte.
// Result channel (m_*): numerator, kind, last flag and clamp flag per item.
// Configuration channel (cfg_*): index and data; taken only when the block
// has drained, and a write abandons any unfinished sample.
// A data byte passes through the command queue and the bit buffer into the
// result register; with the back end idle the rest of its results follow one
// per cycle while m_ready holds. A header holds the input through the front
// end's row, count and push states; unphased it needs two binomial coefficients
// from the shared iterative unit, one multiply and divide per factor and at most
// four factors each, so the hold depends on ploidy and allele count, plus any wait for queue space.
// A four-entry command queue lets the front end go on accepting while the
// back end waits on a stalled receiver; the result register holds its item
// until m_ready. Reset loads the default configuration and empties the bit
// buffer; no clearing pass is needed.
// Depends on ppu_pkg, ppu_front, ppu_queue, ppu_back and ppu_choose.
module packed_probability_unpacker_unit
    import ppu_pkg::*;
#(
    parameter int ROW_MAX        = ROW_MAX_DEF,
    parameter int VALUE_BITS_MAX = VALUE_BITS_MAX_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_cmd,
    input  logic [BYTE_W-1:0] s_payload,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [NUM_W-1:0]  m_numerator,
    output logic [1:0]        m_kind,
    output logic              m_last,
    output logic              m_sum_exceeded,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [CFG_W-1:0]  cfg_data
);
    ppu_cfg_t         cfg_reg;
    logic [CFG_W-1:0] eff_bits;
    logic             cfg_write, front_idle, back_idle, q_full, q_empty, q_push, q_pop;
    ppu_cmd_t         q_wdata, q_rdata;

    assign eff_bits = (cfg_reg.value_bits == '0) ? CFG_W'(1) :
                      (cfg_reg.value_bits > CFG_W'(VALUE_BITS_MAX)) ? CFG_W'(VALUE_BITS_MAX) :
                      cfg_reg.value_bits;

    assign cfg_ready = front_idle && back_idle && q_empty;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.phased       <= 1'b0;
            cfg_reg.value_bits   <= CFG_W'(8);
            cfg_reg.alleles      <= CFG_W'(2);
            cfg_reg.ploidy_limit <= CFG_W'(2);
        end else if (cfg_write) begin
            unique case (cfg_index)
                REG_PHASED:  cfg_reg.phased       <= cfg_data[0];
                REG_VBITS:   cfg_reg.value_bits   <= cfg_data;
                REG_ALLELES: cfg_reg.alleles      <= cfg_data;
                REG_PLOIDY:  cfg_reg.ploidy_limit <= cfg_data;
                default: ;
            endcase
        end
    end

    ppu_front #(.ROW_MAX(ROW_MAX)) u_front (
        .aclk(aclk), .aresetn(aresetn), .cfg(cfg_reg), .eff_bits(eff_bits),
        .s_valid(s_valid), .s_ready(s_ready), .s_cmd(s_cmd), .s_payload(s_payload),
        .q_full(q_full), .q_push(q_push), .q_wdata(q_wdata), .idle(front_idle)
    );

    ppu_queue u_queue (
        .aclk(aclk), .aresetn(aresetn), .push(q_push), .wdata(q_wdata),
        .pop(q_pop), .rdata(q_rdata), .full(q_full), .empty(q_empty)
    );

    ppu_back u_back (
        .aclk(aclk), .aresetn(aresetn), .eff_bits(eff_bits), .cfg_clear(cfg_write),
        .q_empty(q_empty), .q_rdata(q_rdata), .q_pop(q_pop), .idle(back_idle),
        .m_valid(m_valid), .m_ready(m_ready), .m_numerator(m_numerator),
        .m_kind(m_kind), .m_last(m_last), .m_sum_exceeded(m_sum_exceeded)
    );
endmodule

### sv/ppu_checker.sv
// Port-level checks for the packed probability unpacker, bound to the top level.
// Uses ppu_pkg for the kind codes.
module ppu_checker
    import ppu_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             m_valid,
    input logic             m_ready,
    input logic [NUM_W-1:0] m_numerator,
    input logic [1:0]       m_kind,
    input logic             m_sum_exceeded,
    input logic             cfg_valid,
    input logic             cfg_ready,
    input logic             s_ready
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_numerator) && $stable(m_kind))
        else $error("result changed while stalled");

    a_nan_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == KIND_NAN |-> m_numerator == '0 && !m_sum_exceeded)
        else $error("padding item carries data");

    a_clamp: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_sum_exceeded |-> m_kind == KIND_COMP && m_numerator == '0)
        else $error("clamp flag on a non-complement item");

    a_cfg_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid && cfg_ready |-> s_ready)
        else $error("configuration taken while the front end is busy");
endmodule

bind packed_probability_unpacker_unit ppu_checker u_ppu_checker (
    .aclk(aclk), .aresetn(aresetn), .m_valid(m_valid), .m_ready(m_ready),
    .m_numerator(m_numerator), .m_kind(m_kind), .m_sum_exceeded(m_sum_exceeded),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .s_ready(s_ready)
);
